// ----- hw/rtl/sha1c_pkg.sv -----
// SHA-1 compression package: widths, initial chaining value, round constants
// and round functions shared by the channel interfaces and the core.
// No dependencies.
package sha1c_pkg;

  localparam int WORD_W     = 32;
  localparam int HASH_WORDS = 5;
  localparam int BLK_WORDS  = 16;
  localparam int ROUNDS     = 80;
  localparam int STAGE_LEN  = 20;
  localparam int ROUND_W    = $clog2(ROUNDS);
  localparam int COUNT_W    = $clog2(BLK_WORDS);
  localparam int LEFT_W     = $clog2(HASH_WORDS + 1);

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t IV [HASH_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [1:0] STG_CH  = 2'd0;
  localparam logic [1:0] STG_PAR = 2'd1;
  localparam logic [1:0] STG_MAJ = 2'd2;
  localparam logic [1:0] STG_PAR2 = 2'd3;

  // stage of a round: one per run of twenty rounds
  function automatic logic [1:0] sha1c_stage(input logic [ROUND_W-1:0] t);
    logic [1:0] s;
    if (t < ROUND_W'(STAGE_LEN)) begin
      s = STG_CH;
    end else if (t < ROUND_W'(2 * STAGE_LEN)) begin
      s = STG_PAR;
    end else if (t < ROUND_W'(3 * STAGE_LEN)) begin
      s = STG_MAJ;
    end else begin
      s = STG_PAR2;
    end
    return s;
  endfunction

  function automatic word_t sha1c_k(input logic [1:0] s);
    word_t k;
    case (s)
      STG_CH:   k = 32'h5A827999;
      STG_PAR:  k = 32'h6ED9EBA1;
      STG_MAJ:  k = 32'h8F1BBCDC;
      default:  k = 32'hCA62C1D6;
    endcase
    return k;
  endfunction

  function automatic word_t sha1c_f(input logic [1:0] s, input word_t b, input word_t c,
                                    input word_t d);
    word_t f;
    case (s)
      STG_CH:  f = (b & c) | (~b & d);
      STG_MAJ: f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

// ----- hw/rtl/sha1c_word_if.sv -----
// Message word channel: valid/ready handshake with one 32-bit word and
// the block flags. Depends on sha1c_pkg.
interface sha1c_word_if import sha1c_pkg::*; ;
  logic  valid;
  logic  ready;
  word_t message_word;
  logic  first_block;
  logic  final_block;

  modport source (output valid, output message_word, output first_block,
                  output final_block, input ready);
  modport sink (input valid, input message_word, input first_block,
                input final_block, output ready);
endinterface

// ----- hw/rtl/sha1c_digest_if.sv -----
// Digest word channel: valid/ready handshake with one 32-bit digest word
// and a last-word mark. Depends on sha1c_pkg.
interface sha1c_digest_if import sha1c_pkg::*; ;
  logic  valid;
  logic  ready;
  word_t digest_word;
  logic  digest_last;

  modport source (output valid, output digest_word, output digest_last, input ready);
  modport sink (input valid, input digest_word, input digest_last, output ready);
endinterface

// ----- hw/rtl/sha1_block_compression_core.sv -----
// SHA-1 block compression core. After a block's sixteenth word the single round
// unit runs one round per cycle, then the add step follows, which for a final block
// waits until the digest buffer has drained; the first digest word is valid the
// cycle after the add step. New blocks are taken only in the load step. Digest words
// leave their own buffer, one per cycle while the sink is ready, while loading goes on.
// Reset (rst, synchronous): chaining value to the SHA-1 initial value, empty.
module sha1_block_compression_core import sha1c_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  sha1c_word_if.sink     message,
  sha1c_digest_if.source digest
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_ADD   = 2'd2;

  logic [1:0]         state;
  logic [ROUND_W-1:0] round;
  logic [COUNT_W-1:0] word_count;
  logic               final_q;
  word_t              sched [BLK_WORDS];
  word_t              a, b, c, d, e;
  word_t              cv [HASH_WORDS];
  word_t              dig [HASH_WORDS];
  logic [LEFT_W-1:0]  dig_left;

  logic               in_xfer;
  logic               out_xfer;
  logic               blk_done;
  logic               add_go;
  logic [1:0]         stage;
  word_t              w_new;
  word_t              t_sum;

  assign message.ready = (state == ST_LOAD);
  assign in_xfer       = message.valid && message.ready;
  assign blk_done      = in_xfer && (word_count == COUNT_W'(BLK_WORDS - 1));

  assign digest.valid       = (dig_left != '0);
  assign digest.digest_word = dig[0];
  assign digest.digest_last = (dig_left == LEFT_W'(1));
  assign out_xfer           = digest.valid && digest.ready;

  // hold in the add step until the digest buffer has drained
  assign add_go = (state == ST_ADD) &&
                  !(final_q && digest.valid && !(out_xfer && digest.digest_last));

  // round unit
  assign stage = sha1c_stage(round);
  assign w_new = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
  assign t_sum = {a[26:0], a[31:27]} + sha1c_f(stage, b, c, d) + e + sha1c_k(stage)
               + sched[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      round      <= '0;
      word_count <= '0;
      final_q    <= 1'b0;
      dig_left   <= '0;
      for (int i = 0; i < HASH_WORDS; i++) begin
        cv[i] <= IV[i];
      end
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_xfer) begin
            word_count <= word_count + COUNT_W'(1);
            if (word_count == '0 && message.first_block) begin
              for (int i = 0; i < HASH_WORDS; i++) begin
                cv[i] <= IV[i];
              end
            end
            if (blk_done) begin
              final_q <= message.final_block;
              round   <= '0;
              state   <= ST_ROUND;
            end
          end
        end
        ST_ROUND: begin
          round <= round + ROUND_W'(1);
          if (round == ROUND_W'(ROUNDS - 1)) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          if (add_go) begin
            cv[0] <= cv[0] + a;
            cv[1] <= cv[1] + b;
            cv[2] <= cv[2] + c;
            cv[3] <= cv[3] + d;
            cv[4] <= cv[4] + e;
            state <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase

      if (add_go && final_q) begin
        dig_left <= LEFT_W'(HASH_WORDS);
      end else if (out_xfer) begin
        dig_left <= dig_left - LEFT_W'(1);
      end
    end
  end

  // payload: schedule window, round variables, digest buffer
  always_ff @(posedge clk) begin
    if (in_xfer || state == ST_ROUND) begin
      for (int i = 0; i < BLK_WORDS - 1; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[BLK_WORDS-1] <= in_xfer ? message.message_word : {w_new[30:0], w_new[31]};
    end

    if (blk_done) begin
      a <= cv[0];
      b <= cv[1];
      c <= cv[2];
      d <= cv[3];
      e <= cv[4];
    end else if (state == ST_ROUND) begin
      a <= t_sum;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end

    if (add_go && final_q) begin
      dig[0] <= cv[0] + a;
      dig[1] <= cv[1] + b;
      dig[2] <= cv[2] + c;
      dig[3] <= cv[3] + d;
      dig[4] <= cv[4] + e;
    end else if (out_xfer) begin
      for (int i = 0; i < HASH_WORDS - 1; i++) begin
        dig[i] <= dig[i+1];
      end
    end
  end

`ifndef ASSERT_OFF
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && round == ROUND_W'(ROUNDS - 1)) |=> (state == ST_ADD))
    else $error("round sequencer did not reach the add step after the last round");

  a_block_start: assert property (@(posedge clk) disable iff (rst)
    blk_done |=> (state == ST_ROUND && round == '0 && word_count == '0))
    else $error("completed block did not start compression at round zero");

  a_dig_bound: assert property (@(posedge clk) disable iff (rst)
    dig_left <= LEFT_W'(HASH_WORDS))
    else $error("digest word count out of range");

  a_dig_load: assert property (@(posedge clk) disable iff (rst)
    (add_go && final_q) |=> (dig_left == LEFT_W'(HASH_WORDS)))
    else $error("digest buffer not loaded after a final block");
`endif

endmodule
